### src/lapf_pkg.sv
`timescale 1ns / 1ps

package lapf_pkg;

  // Frame limits
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  // Field and counter widths
  localparam int unsigned PixW  = 8;
  localparam int unsigned DimW  = 11;
  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned OutRowW = $clog2(MaxHeight);
  localparam int unsigned InRowW  = $clog2(MaxHeight + 1);

  // Three row stores rotate over the rows of the frame
  localparam int unsigned NumStores = 3;
  localparam int unsigned SelW      = 2;

  // Configuration port
  localparam int unsigned AddrW  = 3;
  localparam int unsigned PDataW = 32;
  localparam logic CfgWidthIdx  = 1'b0;
  localparam logic CfgHeightIdx = 1'b1;

  // Register reset values
  localparam logic [DimW-1:0] WidthReset  = DimW'(640);
  localparam logic [DimW-1:0] HeightReset = DimW'(480);

  // Input item kinds
  localparam logic ActPixel = 1'b0;
  localparam logic ActDrain = 1'b1;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [ColW-1:0] col_t;

endpackage

### src/laplacian_3x3_mirror_filter.sv
`timescale 1ns / 1ps

// 3x3 four-neighbor Laplacian over an 8-bit raster stream, mirrored borders
// (index -1 reads 1, index N reads N-2), result = min(255, 8*|sum|). Takes one
// item per clock while the output side keeps up; a result passes through stage 1
// and then the output register, where it may wait while the
// next item is taken. Results lag the input by one row: the result for (r,c)
// leaves with pixel (r+1,c), and the last row leaves on drain items once the
// frame's last pixel is in. Drains before that, and pixels after it, are
// ignored. Rows live in three 1024x8 stores, each with one write and two read
// ports; every item is one store access, which sets the rate. Store
// contents need no clearing after reset, so items are taken right away.
// A width or height write restarts the frame.
module laplacian_3x3_mirror_filter
  import lapf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              action_i,
  input  logic [PixW-1:0]   pixel_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PixW-1:0]   filtered_o,
  output logic              frame_end_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready
);

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    if (v < DimW'(2)) begin
      r = DimW'(2);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // registers
  logic [DimW-1:0]    w_q, w_d;
  logic [DimW-1:0]    h_q, h_d;
  logic [InRowW-1:0]  in_row_q, in_row_d;
  col_t               in_col_q, in_col_d;
  logic [SelW-1:0]    in_sel_q, in_sel_d;
  logic [OutRowW-1:0] out_row_q, out_row_d;
  col_t               out_col_q, out_col_d;

  logic               s1_valid_q, s1_valid_d;
  logic               s1_col0_q, s1_rfirst_q, s1_rlast_q, s1_last_q;
  pix_t               s1_down_q;
  logic [SelW-1:0]    s1_csel_q, s1_usel_q;

  logic               out_valid_q, out_valid_d;
  pix_t               filtered_q;
  logic               frame_end_q;
  pix_t               prev_center_q;

  // handshake decode
  logic cfg_wr, in_fire, is_drain, frame_done, emit, px_write, s1_adv;
  logic last_out, out_rlast;
  col_t rd_addr_b;
  logic [SelW-1:0] csel, usel;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign s1_adv   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire  = in_valid_i && in_ready_o;
  assign is_drain = (action_i == ActDrain);
  assign frame_done = (in_row_q >= InRowW'(h_q));
  assign emit     = in_fire && (is_drain ? frame_done : (!frame_done && in_row_q != '0));
  assign px_write = in_fire && !is_drain && !frame_done;

  assign out_rlast = ({1'b0, out_row_q} == DimW'(h_q - DimW'(1)));
  assign last_out  = out_rlast && ({1'b0, out_col_q} == DimW'(w_q - DimW'(1)));

  // right neighbor column, mirrored at the right edge
  assign rd_addr_b = ({1'b0, out_col_q} >= DimW'(w_q - DimW'(1)))
                   ? ColW'(w_q - DimW'(2)) : ColW'(out_col_q + col_t'(1));

  // store of the output row and of the row above it
  always_comb begin
    case (in_sel_q)
      2'd0:    begin csel = 2'd2; usel = 2'd1; end
      2'd1:    begin csel = 2'd0; usel = 2'd2; end
      2'd2:    begin csel = 2'd1; usel = 2'd0; end
      default: begin csel = 2'd0; usel = 2'd0; end
    endcase
  end

  // position counters and configuration
  always_comb begin
    w_d       = w_q;
    h_d       = h_q;
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    in_sel_d  = in_sel_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (cfg_wr) begin
      if (paddr[2] == CfgWidthIdx) begin
        w_d = clamp_dim(pwdata[DimW-1:0], DimW'(MaxWidth));
      end else begin
        h_d = clamp_dim(pwdata[DimW-1:0], DimW'(MaxHeight));
      end
      in_row_d  = '0;
      in_col_d  = '0;
      in_sel_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
    end else begin
      if (px_write) begin
        if ({1'b0, in_col_q} >= DimW'(w_q - DimW'(1))) begin
          in_col_d = '0;
          in_row_d = in_row_q + InRowW'(1);
          in_sel_d = (in_sel_q == 2'd2) ? 2'd0 : in_sel_q + 2'd1;
        end else begin
          in_col_d = in_col_q + col_t'(1);
        end
      end
      if (emit) begin
        if (last_out) begin
          in_row_d  = '0;
          in_col_d  = '0;
          in_sel_d  = '0;
          out_row_d = '0;
          out_col_d = '0;
        end else if ({1'b0, out_col_q} >= DimW'(w_q - DimW'(1))) begin
          out_col_d = '0;
          out_row_d = out_row_q + OutRowW'(1);
        end else begin
          out_col_d = out_col_q + col_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= WidthReset;
      h_q       <= HeightReset;
      in_row_q  <= '0;
      in_col_q  <= '0;
      in_sel_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else begin
      w_q       <= w_d;
      h_q       <= h_d;
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      in_sel_q  <= in_sel_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    if (paddr[2] == CfgWidthIdx) begin
      prdata[DimW-1:0] = w_q;
    end else if (paddr[2] == CfgHeightIdx) begin
      prdata[DimW-1:0] = h_q;
    end
  end

  // row stores
  pix_t rd_a [NumStores];
  pix_t rd_b [NumStores];

  for (genvar k = 0; k < NumStores; k++) begin : g_store
    lapf_line_store u_store (
      .clk_i     (clk_i),
      .we_i      (px_write && (in_sel_q == SelW'(k))),
      .waddr_i   (in_col_q),
      .wdata_i   (pixel_i),
      .re_i      (emit),
      .raddr_a_i (out_col_q),
      .raddr_b_i (rd_addr_b),
      .rdata_a_o (rd_a[k]),
      .rdata_b_o (rd_b[k])
    );
  end

  // stage 1: window control travels with the store reads
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (emit) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_col0_q   <= (out_col_q == '0);
      s1_rfirst_q <= (out_row_q == '0);
      s1_rlast_q  <= out_rlast;
      s1_last_q   <= last_out;
      s1_down_q   <= pixel_i;
      s1_csel_q   <= csel;
      s1_usel_q   <= usel;
    end
  end

  // kernel and saturation
  pix_t center, right_px, left_px, upper_raw, down_px, up_px;
  logic signed [PixW+3:0] lap_sum;
  logic [PixW+2:0] lap_mag;
  pix_t lap_out;

  assign center    = rd_a[s1_csel_q];
  assign right_px  = rd_b[s1_csel_q];
  assign left_px   = s1_col0_q ? right_px : prev_center_q;
  assign upper_raw = rd_a[s1_usel_q];
  assign down_px   = s1_rlast_q ? upper_raw : s1_down_q;
  assign up_px     = s1_rfirst_q ? down_px : upper_raw;

  always_comb begin
    lap_sum = $signed({4'b0, up_px}) + $signed({4'b0, down_px})
            + $signed({4'b0, left_px}) + $signed({4'b0, right_px})
            - $signed({2'b0, center, 2'b0});
    lap_mag = lap_sum[PixW+3] ? (PixW+3)'(-lap_sum) : lap_sum[PixW+2:0];
    if (lap_mag > (PixW+3)'(31)) begin
      lap_out = 8'd255;
    end else begin
      lap_out = {lap_mag[4:0], 3'b000};
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      filtered_q    <= lap_out;
      frame_end_q   <= s1_last_q;
      prev_center_q <= center;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign frame_end_o = frame_end_q;

`ifndef SYNTHESIS
  // input position never runs past the frame
  a_in_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q <= InRowW'(h_q))
    else $error("input row beyond frame height");

  // output row trails the input row
  a_out_trails_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (InRowW'(out_row_q) < in_row_q) || (in_row_q == '0 && out_row_q == '0))
    else $error("output row not behind input row");

  // stage 1 blocked by a held result stops new items
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while pipeline is stalled");
`endif

endmodule

### src/lapf_line_store.sv
`timescale 1ns / 1ps

// One row store: one write port, two registered read ports.
module lapf_line_store
  import lapf_pkg::*;
(
  input  logic clk_i,
  input  logic we_i,
  input  col_t waddr_i,
  input  pix_t wdata_i,
  input  logic re_i,
  input  col_t raddr_a_i,
  input  col_t raddr_b_i,
  output pix_t rdata_a_o,
  output pix_t rdata_b_o
);

  pix_t mem_q [MaxWidth];
  pix_t rdata_a_q;
  pix_t rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read ports, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### bench/laplacian_3x3_mirror_filter_tb.sv
`timescale 1ns / 1ps

module laplacian_3x3_mirror_filter_tb;
  import lapf_pkg::*;

  localparam int unsigned RandomItems = 700;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit = 200_000;

  typedef struct packed {
    pix_t filtered;
    logic frame_end;
  } lap_result_t;

  // pixel content styles for generated frames
  typedef enum int unsigned {PixNoise, PixSmooth, PixBinary, PixFlat} pix_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              action_i;
  logic [PixW-1:0]   pixel_i;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [PixW-1:0]   filtered_o;
  logic              frame_end_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic              pready;

  laplacian_3x3_mirror_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .filtered_o  (filtered_o),
    .frame_end_o (frame_end_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shared bench state
  lap_result_t pending_px[$];
  int unsigned mismatch_cnt = 0;
  int unsigned used_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_req = 0;
  bit          idle_on = 1'b1;

  // Filter shadow: three rotating row stores plus frame positions
  pix_t        row_mem [NumStores][MaxWidth];
  int unsigned cfg_w, cfg_h;
  int unsigned in_r, in_c, out_r, out_c;

  function automatic int unsigned fit_dim(logic [31:0] value, int unsigned limit);
    int unsigned d;
    d = 32'(value[DimW-1:0]);
    if (d < 2) return 2;
    if (d > limit) return limit;
    return d;
  endfunction

  function automatic void frame_restart();
    in_r = 0;
    in_c = 0;
    out_r = 0;
    out_c = 0;
  endfunction

  function automatic void shadow_dim(logic idx, logic [31:0] value);
    if (idx == CfgWidthIdx) begin
      cfg_w = fit_dim(value, MaxWidth);
    end else begin
      cfg_h = fit_dim(value, MaxHeight);
    end
    frame_restart();
  endfunction

  function automatic pix_t stored_px(int unsigned r, int unsigned c);
    return row_mem[r % NumStores][c % MaxWidth];
  endfunction

  // 4-neighbor Laplacian with mirrored borders, scaled by 8 and saturated
  function automatic pix_t laplace_at(int unsigned r, int unsigned c);
    int unsigned ru, rd, cl, cr;
    int sum, mag;
    ru = (r == 0) ? 1 : r - 1;
    rd = (r >= cfg_h - 1) ? cfg_h - 2 : r + 1;
    cl = (c == 0) ? 1 : c - 1;
    cr = (c >= cfg_w - 1) ? cfg_w - 2 : c + 1;
    sum = int'(stored_px(ru, c)) + int'(stored_px(rd, c)) + int'(stored_px(r, cl))
        + int'(stored_px(r, cr)) - 4 * int'(stored_px(r, c));
    mag = (sum < 0) ? -sum : sum;
    return (8 * mag > 255) ? 8'hFF : pix_t'(8 * mag);
  endfunction

  function automatic void queue_next_result();
    lap_result_t res;
    bit is_last;
    is_last = (out_r == cfg_h - 1) && (out_c == cfg_w - 1);
    res.filtered = laplace_at(out_r, out_c);
    res.frame_end = is_last;
    pending_px.push_back(res);
    if (is_last) begin
      frame_restart();
    end else if (out_c >= cfg_w - 1) begin
      out_c = 0;
      out_r++;
    end else begin
      out_c++;
    end
  endfunction

  // Returns 1 when the item does something (pixel stored or drain emits)
  function automatic bit shadow_take(logic act, pix_t pix);
    bit frame_full;
    bit row_ready;
    frame_full = (in_r >= cfg_h);
    if (act == ActDrain) begin
      if (!frame_full) return 1'b0;
      queue_next_result();
      return 1'b1;
    end
    if (frame_full) return 1'b0;
    row_mem[in_r % NumStores][in_c % MaxWidth] = pix;
    row_ready = (in_r >= 1);
    if (in_c >= cfg_w - 1) begin
      in_c = 0;
      in_r++;
    end else begin
      in_c++;
    end
    if (row_ready) queue_next_result();
    return 1'b1;
  endfunction

  function automatic void report_mismatch(string what, int unsigned want, int unsigned got);
    if (mismatch_cnt < 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
    mismatch_cnt++;
  endfunction

  function automatic pix_t make_pixel(pix_mode_e mode, int unsigned base);
    case (mode)
      PixNoise:  return pix_t'($urandom);
      PixSmooth: return pix_t'(base + $urandom_range(0, 3));
      PixBinary: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default:   return pix_t'(base);
    endcase
  endfunction

  // Register value for a dimension: sometimes below range, sometimes with junk upper bits
  function automatic logic [31:0] dim_code(int unsigned d);
    if (d == 2 && $urandom_range(0, 1) == 0) return 32'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) return 32'(d) | ($urandom << DimW);
    return 32'(d);
  endfunction

  // One input transfer; valid stays up until the block takes it
  task automatic send_item(logic act, pix_t pix);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 11) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    pixel_i <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    if (shadow_take(act, pix)) used_cnt++;
  endtask

  // Stop sending, wait for every pending result, then let the pipeline empty
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_dim(logic idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_dim(idx, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Register read: setup then access, data checked at the access edge
  task automatic check_dim(logic idx, int unsigned want);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= AddrW'({idx, 2'b00});
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PDataW'(want)) report_mismatch("register readback", want, prdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Whole frame, then drains for the last row; noise adds items the block ignores
  task automatic run_frame(int unsigned w, int unsigned h, pix_mode_e mode, bit noisy);
    int unsigned base;
    base = $urandom_range(0, 255);
    for (int unsigned i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 39) == 0) send_item(ActDrain, pix_t'($urandom));
      send_item(ActPixel, make_pixel(mode, base));
    end
    for (int unsigned i = 0; i < w; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_item(ActPixel, pix_t'($urandom));
      send_item(ActDrain, pix_t'($urandom));
    end
    if (noisy && $urandom_range(0, 5) == 0) send_item(ActDrain, pix_t'($urandom));
  endtask

  // Default 640-wide rows: a row and a bit gives the first results
  task automatic test_reset_dims();
    check_dim(CfgWidthIdx, cfg_w);
    check_dim(CfgHeightIdx, cfg_h);
    for (int unsigned i = 0; i < 650; i++) send_item(ActPixel, pix_t'($urandom));
  endtask

  task automatic test_corner_items();
    pix_t ramp [9] = '{8'd10, 8'd11, 8'd10, 8'd12, 8'd14, 8'd12, 8'd10, 8'd11, 8'd10};
    settle();
    // below-range dimensions act as 2x2
    write_dim(CfgWidthIdx, 32'd1);
    write_dim(CfgHeightIdx, 32'd0);
    send_item(ActPixel, 8'h00);
    send_item(ActDrain, 8'hFF);    // early drain, ignored
    send_item(ActPixel, 8'hFF);
    send_item(ActPixel, 8'hFF);
    send_item(ActPixel, 8'h00);
    send_item(ActPixel, 8'd77);    // frame full with results pending: dropped
    send_item(ActDrain, 8'h00);
    send_item(ActDrain, 8'h00);
    send_item(ActDrain, 8'h00);    // after frame end, ignored
    settle();
    // upper bits of the register value are dropped: 3x3, small unsaturated results
    write_dim(CfgWidthIdx, 32'hFFFF_F803);
    write_dim(CfgHeightIdx, 32'd3);
    foreach (ramp[i]) send_item(ActPixel, ramp[i]);
    repeat (3) send_item(ActDrain, 8'h00);
  endtask

  // Register write in the middle of a frame abandons it
  task automatic test_mid_frame_write();
    settle();
    write_dim(CfgWidthIdx, 32'd5);
    write_dim(CfgHeightIdx, 32'd4);
    for (int unsigned i = 0; i < 13; i++) send_item(ActPixel, pix_t'($urandom));
    settle();
    write_dim(CfgWidthIdx, 32'd5);
    run_frame(5, 4, PixSmooth, 1'b0);
  endtask

  // Out-of-range values clamp to the limits; readback shows the value in use
  task automatic test_extreme_dims();
    settle();
    write_dim(CfgWidthIdx, 32'd2047);
    write_dim(CfgHeightIdx, 32'd0);
    check_dim(CfgWidthIdx, MaxWidth);
    check_dim(CfgHeightIdx, 2);
    write_dim(CfgWidthIdx, 32'd1);
    write_dim(CfgHeightIdx, 32'h0000_17FF);
    check_dim(CfgWidthIdx, 2);
    check_dim(CfgHeightIdx, MaxHeight);
  endtask

  // Output held off long enough that the input side must stall
  task automatic test_backpressure();
    settle();
    write_dim(CfgWidthIdx, 32'd16);
    write_dim(CfgHeightIdx, 32'd6);
    hold_req = 300;
    run_frame(16, 6, PixSmooth, 1'b0);
    settle();
  endtask

  task automatic test_random_frames();
    int unsigned w, h, n;
    bit need_cfg;
    need_cfg = 1'b1;
    w = 2;
    h = 2;
    used_cnt = 0;
    while (used_cnt < RandomItems) begin
      if (need_cfg || $urandom_range(0, 2) == 0) begin
        settle();
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(2, 12);
        h = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 8);
        write_dim(CfgWidthIdx, dim_code(w));
        write_dim(CfgHeightIdx, dim_code(h));
        need_cfg = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        settle();
      end
      if ($urandom_range(0, 7) == 0) begin
        // broken frame: cut short, abandoned by the next register write
        n = $urandom_range(1, w * h - 1);
        for (int unsigned i = 0; i < n; i++) send_item(ActPixel, pix_t'($urandom));
        need_cfg = 1'b1;
      end else begin
        run_frame(w, h, pix_mode_e'($urandom_range(0, 3)), 1'b1);
      end
    end
  endtask

  // Back-to-back frames at full rate on both sides
  task automatic test_full_rate();
    int unsigned w, h;
    settle();
    idle_on = 1'b0;
    repeat (3) begin
      settle();
      w = $urandom_range(2, 12);
      h = $urandom_range(2, 6);
      write_dim(CfgWidthIdx, 32'(w));
      write_dim(CfgHeightIdx, 32'(h));
      run_frame(w, h, PixNoise, 1'b0);
      run_frame(w, h, PixSmooth, 1'b0);
    end
  endtask

  // Result checker: every output transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_px.size() == 0) begin
        report_mismatch("unexpected result, filtered", 0, filtered_o);
      end else begin
        if (filtered_o !== pending_px[0].filtered) begin
          report_mismatch("filtered", pending_px[0].filtered, filtered_o);
        end
        if (frame_end_o !== pending_px[0].frame_end) begin
          report_mismatch("frame_end", pending_px[0].frame_end, frame_end_o);
        end
        void'(pending_px.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus a long counted hold-off on request
  initial begin : out_side
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        n = hold_req;
        hold_req = 0;
        out_ready_i <= 1'b0;
        repeat (n) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    in_valid_i = 1'b0;
    action_i = ActPixel;
    pixel_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (row_mem[s, c]) row_mem[s][c] = '0;
    cfg_w = fit_dim(32'(WidthReset), MaxWidth);
    cfg_h = fit_dim(32'(HeightReset), MaxHeight);
    frame_restart();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_dims();
    test_corner_items();
    test_mid_frame_write();
    test_extreme_dims();
    test_backpressure();
    test_random_frames();
    test_full_rate();

    settle();
    if (mismatch_cnt == 0 && pending_px.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
